// ===== design/imm_pkg.sv =====
//------------------------------------------------------------------------------
// imm_pkg
// Shared constants, types and helpers of the integer matrix multiplier.
//------------------------------------------------------------------------------
`default_nettype none

package imm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int IDX_W      = 3;
   localparam int DIM_W      = 4;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int DATA_W     = 32;
   localparam int OPC_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = 2;
   localparam int Q_CNT_W    = 3;

   typedef logic [OPC_W-1:0]     opcode_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam opcode_type OP_LOAD_A  = 2'd0;
   localparam opcode_type OP_LOAD_B  = 2'd1;
   localparam opcode_type OP_COMPUTE = 2'd2;

   localparam csr_index_type CSR_ROWS_A    = 2'd0;
   localparam csr_index_type CSR_INNER_DIM = 2'd1;
   localparam csr_index_type CSR_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      CMD_LOAD_A,
      CMD_LOAD_B,
      CMD_COMPUTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [DATA_W-1:0]  value;
      logic [DIM_W-1:0]          rows_a;
      logic [DIM_W-1:0]          inner_dim;
      logic [DIM_W-1:0]          cols_b;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic                 a_we;
      logic                 b_we;
      logic [ADDR_W-1:0]    addr;
      logic [DATA_W-1:0]    data;
   } ram_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FINISH
   } back_state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/imm_if.sv =====
//------------------------------------------------------------------------------
// imm_req_if / imm_rsp_if
// Valid/ready channels carrying request words and product words.
//------------------------------------------------------------------------------
`default_nettype none

interface imm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [imm_pkg::OPC_W-1:0]             opcode;
   logic [imm_pkg::IDX_W-1:0]             row;
   logic [imm_pkg::IDX_W-1:0]             col;
   logic signed [imm_pkg::DATA_W-1:0]     value;

   modport source (output valid, opcode, row, col, value, input ready);
   modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

interface imm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [imm_pkg::IDX_W-1:0]             out_row;
   logic [imm_pkg::IDX_W-1:0]             out_col;
   logic signed [imm_pkg::DATA_W-1:0]     product;
   logic                                  last;

   modport source (output valid, out_row, out_col, product, last, input ready);
   modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

`default_nettype wire

// ===== design/imm_ram.sv =====
//------------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module imm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/imm_front.sv =====
//------------------------------------------------------------------------------
// imm_front
// Accepts request words, holds the size registers and classifies each word
// into a command for the back end.
//------------------------------------------------------------------------------
`default_nettype none

module imm_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   imm_req_if.sink                                req_chan,
   input  wire logic                              csr_we,
   input  wire logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [imm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire imm_pkg::q_stat_type               q_stat,
   output logic                                   q_push,
   output imm_pkg::cmd_type                       q_cmd
);

   logic [imm_pkg::DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [imm_pkg::DIM_W-1:0] inner_dim_ff, inner_dim_in;
   logic [imm_pkg::DIM_W-1:0] cols_b_ff, cols_b_in;
   logic                      keep;
   imm_pkg::cmd_kind_type     kind;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      if (csr_we) begin
         unique case (csr_index)
            imm_pkg::CSR_ROWS_A:    rows_a_in    = csr_wdata;
            imm_pkg::CSR_INNER_DIM: inner_dim_in = csr_wdata;
            imm_pkg::CSR_COLS_B:    cols_b_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= imm_pkg::DIM_RESET;
         inner_dim_ff <= imm_pkg::DIM_RESET;
         cols_b_ff    <= imm_pkg::DIM_RESET;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   always_comb begin
      keep = 1'b1;
      kind = imm_pkg::CMD_COMPUTE;
      unique case (req_chan.opcode)
         imm_pkg::OP_LOAD_A:  kind = imm_pkg::CMD_LOAD_A;
         imm_pkg::OP_LOAD_B:  kind = imm_pkg::CMD_LOAD_B;
         imm_pkg::OP_COMPUTE: kind = imm_pkg::CMD_COMPUTE;
         default:             keep = 1'b0;
      endcase
   end

   assign req_chan.ready = !q_stat.full;
   assign q_push = req_chan.valid && !q_stat.full && keep;

   always_comb begin
      q_cmd.kind      = kind;
      q_cmd.row       = req_chan.row;
      q_cmd.col       = req_chan.col;
      q_cmd.value     = req_chan.value;
      q_cmd.rows_a    = imm_pkg::clamp_dim(rows_a_ff);
      q_cmd.inner_dim = imm_pkg::clamp_dim(inner_dim_ff);
      q_cmd.cols_b    = imm_pkg::clamp_dim(cols_b_ff);
   end

endmodule

`default_nettype wire

// ===== design/imm_queue.sv =====
//------------------------------------------------------------------------------
// imm_queue
// Short command queue between the front end and the back end.
//------------------------------------------------------------------------------
`default_nettype none

module imm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire imm_pkg::cmd_type   cmd_in,
   input  wire logic               pop,
   output imm_pkg::cmd_type        cmd_out,
   output imm_pkg::q_stat_type     stat
);

   imm_pkg::cmd_type                mem_ff [imm_pkg::Q_DEPTH];
   logic [imm_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [imm_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [imm_pkg::Q_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                            do_push;
   logic                            do_pop;

   assign stat.full  = (cnt_ff == imm_pkg::Q_CNT_W'(imm_pkg::Q_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign cmd_out    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/imm_back.sv =====
//------------------------------------------------------------------------------
// imm_back
// Executes queued commands: writes loads into the stores and walks the
// product with one shared multiply-accumulate, one element at a time.
//------------------------------------------------------------------------------
`default_nettype none

module imm_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire imm_pkg::cmd_type               cmd,
   input  wire imm_pkg::q_stat_type            q_stat,
   output logic                                q_pop,
   output imm_pkg::ram_wr_type                 ram_wr,
   output logic [imm_pkg::ADDR_W-1:0]          a_raddr,
   output logic [imm_pkg::ADDR_W-1:0]          b_raddr,
   input  wire logic [imm_pkg::DATA_W-1:0]     a_rdata,
   input  wire logic [imm_pkg::DATA_W-1:0]     b_rdata,
   imm_rsp_if.source                           rsp_chan
);

   imm_pkg::back_state_type state_ff, state_in;

   logic [imm_pkg::IDX_W-1:0]  i_ff, i_in;
   logic [imm_pkg::IDX_W-1:0]  k_ff, k_in;
   logic [imm_pkg::IDX_W-1:0]  j_ff, j_in;
   logic [imm_pkg::DIM_W-1:0]  n_ff, n_in;
   logic [imm_pkg::DIM_W-1:0]  m_ff, m_in;
   logic [imm_pkg::DIM_W-1:0]  p_ff, p_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       mul_vld_ff, mul_vld_in;
   logic [imm_pkg::DATA_W-1:0] prod_ff, prod_in;
   logic [imm_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [imm_pkg::IDX_W-1:0]  out_row_ff, out_row_in;
   logic [imm_pkg::IDX_W-1:0]  out_col_ff, out_col_in;
   logic [imm_pkg::DATA_W-1:0] out_prod_ff, out_prod_in;
   logic                       out_last_ff, out_last_in;

   logic out_free;
   logic pipe_empty;
   logic j_end;
   logic k_end;
   logic i_end;
   logic start;
   logic issue;
   logic emit;

   assign out_free   = !rsp_vld_ff || rsp_chan.ready;
   assign pipe_empty = !rd_vld_ff && !mul_vld_ff;
   assign j_end      = ({1'b0, j_ff} == m_ff - 1'b1);
   assign k_end      = ({1'b0, k_ff} == p_ff - 1'b1);
   assign i_end      = ({1'b0, i_ff} == n_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (!q_stat.empty && cmd.kind == imm_pkg::CMD_COMPUTE) begin
               state_in = imm_pkg::ST_ISSUE;
            end
         end
         imm_pkg::ST_ISSUE: begin
            if (j_end) begin
               state_in = imm_pkg::ST_FINISH;
            end
         end
         imm_pkg::ST_FINISH: begin
            if (pipe_empty && out_free) begin
               state_in = (i_end && k_end) ? imm_pkg::ST_IDLE : imm_pkg::ST_ISSUE;
            end
         end
         default: state_in = imm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      start       = 1'b0;
      issue       = 1'b0;
      emit        = 1'b0;
      ram_wr.a_we = 1'b0;
      ram_wr.b_we = 1'b0;
      ram_wr.addr = {cmd.row, cmd.col};
      ram_wr.data = cmd.value;
      unique case (state_ff)
         imm_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop       = 1'b1;
               ram_wr.a_we = (cmd.kind == imm_pkg::CMD_LOAD_A);
               ram_wr.b_we = (cmd.kind == imm_pkg::CMD_LOAD_B);
               start       = (cmd.kind == imm_pkg::CMD_COMPUTE);
            end
         end
         imm_pkg::ST_ISSUE: begin
            issue = 1'b1;
         end
         imm_pkg::ST_FINISH: begin
            emit = pipe_empty && out_free;
         end
         default: ;
      endcase
   end

   assign a_raddr = {i_ff, j_ff};
   assign b_raddr = {j_ff, k_ff};

   always_comb begin
      n_in        = n_ff;
      m_in        = m_ff;
      p_in        = p_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      acc_in      = acc_ff;
      rd_vld_in   = issue;
      mul_vld_in  = rd_vld_ff;
      prod_in     = imm_pkg::DATA_W'(a_rdata * b_rdata);
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_prod_in = out_prod_ff;
      out_last_in = out_last_ff;
      if (mul_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
      if (start) begin
         n_in   = cmd.rows_a;
         m_in   = cmd.inner_dim;
         p_in   = cmd.cols_b;
         i_in   = '0;
         k_in   = '0;
         j_in   = '0;
         acc_in = '0;
      end
      if (issue) begin
         j_in = j_end ? '0 : j_ff + 1'b1;
      end
      if (emit) begin
         rsp_vld_in  = 1'b1;
         out_row_in  = i_ff;
         out_col_in  = k_ff;
         out_prod_in = acc_ff;
         out_last_in = i_end && k_end;
         acc_in      = '0;
         j_in        = '0;
         if (k_end) begin
            k_in = '0;
            i_in = i_ff + 1'b1;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= imm_pkg::ST_IDLE;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         mul_vld_ff <= mul_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      m_ff        <= m_in;
      p_ff        <= p_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_prod_ff <= out_prod_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.out_row = out_row_ff;
   assign rsp_chan.out_col = out_col_ff;
   assign rsp_chan.product = $signed(out_prod_ff);
   assign rsp_chan.last    = out_last_ff;

endmodule

`default_nettype wire

// ===== design/int_matrix_multiply.sv =====
//------------------------------------------------------------------------------
// int_matrix_multiply
// Integer matrix multiplier: loads A and B element by element and streams
// out C = A * B row-major with 32-bit wraparound.
//------------------------------------------------------------------------------
// A load word is taken into a four-entry command queue and written to its
// store when the back end pops it; loads sustain one word per cycle while
// no compute is in progress. A compute word makes the back end walk C one
// element at a time through a single registered-read store port pair and
// one 32x32 multiplier followed by an accumulator: for each element it
// issues inner_dim reads, lets the registered read data and the registered
// product drain into the accumulator, then emits the sum. Words queued
// behind a compute wait until its last element has been emitted. Size
// registers of 0 act as 1, values above 8 act as 8; opcode 3 is dropped.
//------------------------------------------------------------------------------
`default_nettype none

module int_matrix_multiply (
   input  wire logic                              clock,
   input  wire logic                              reset,
   imm_req_if.sink                                req_chan,
   imm_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [imm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [imm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                              q_push;
   logic                              q_pop;
   imm_pkg::cmd_type                  q_cmd_in;
   imm_pkg::cmd_type                  q_cmd_out;
   imm_pkg::q_stat_type               q_stat;
   imm_pkg::ram_wr_type               ram_wr;
   logic [imm_pkg::ADDR_W-1:0]        a_raddr;
   logic [imm_pkg::ADDR_W-1:0]        b_raddr;
   logic [imm_pkg::DATA_W-1:0]        a_rdata;
   logic [imm_pkg::DATA_W-1:0]        b_rdata;

   imm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (q_cmd_in)
   );

   imm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (q_cmd_in),
      .pop     (q_pop),
      .cmd_out (q_cmd_out),
      .stat    (q_stat)
   );

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (imm_pkg::STORE_DEPTH)
   ) u_a_store (
      .clock (clock),
      .we    (ram_wr.a_we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   imm_ram #(
      .WIDTH (imm_pkg::DATA_W),
      .DEPTH (imm_pkg::STORE_DEPTH)
   ) u_b_store (
      .clock (clock),
      .we    (ram_wr.b_we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   imm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (q_cmd_out),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .ram_wr   (ram_wr),
      .a_raddr  (a_raddr),
      .b_raddr  (b_raddr),
      .a_rdata  (a_rdata),
      .b_rdata  (b_rdata),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== design/imm_checker.sv =====
//------------------------------------------------------------------------------
// imm_checker
// Port-level assertions on the product channel, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module imm_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic [imm_pkg::IDX_W-1:0]        rsp_out_row,
   input  wire logic [imm_pkg::IDX_W-1:0]        rsp_out_col,
   input  wire logic [imm_pkg::DATA_W-1:0]       rsp_product,
   input  wire logic                             rsp_last
);

   logic first_ff, first_in;

   always_comb begin
      first_in = first_ff;
      if (rsp_valid && rsp_ready) begin
         first_in = rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("product word valid right after reset");

   a_first_elem: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && first_ff) |-> (rsp_out_row == '0 && rsp_out_col == '0))
      else $error("product does not start at element zero");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("product word dropped while stalled");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         $stable({rsp_out_row, rsp_out_col, rsp_product, rsp_last}))
      else $error("product word changed while stalled");

endmodule

bind int_matrix_multiply imm_checker u_imm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_out_row (rsp_chan.out_row),
   .rsp_out_col (rsp_chan.out_col),
   .rsp_product (rsp_chan.product),
   .rsp_last    (rsp_chan.last)
);

`default_nettype wire

// ===== tb/int_matrix_multiply_tb.sv =====
//------------------------------------------------------------------------------
// int_matrix_multiply_tb
// Self-checking bench for the integer matrix multiplier. A short directed
// table covers size clamping, the unused opcode, ignored fields on compute and
// wraparound at the extremes. It is followed by random phases. Each phase
// sets the sizes, loads A and B, and issues compute words. Every product word
// is checked against the table or an in-bench copy of both stores. Both
// channels idle at random and the result side holds off once for a long stretch.
//------------------------------------------------------------------------------
`default_nettype none

module int_matrix_multiply_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import imm_pkg::*;

   localparam int DRAIN_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_WORDS  = 480;

   localparam opcode_type OP_UNUSED = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]         row_idx;
      logic [IDX_W-1:0]         col_idx;
      logic signed [DATA_W-1:0] product;
      logic                     last;
   } product_elem_type;

   typedef enum bit {STEP_CSR, STEP_WORD} step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic [1:0]        code;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
      bit                typed;
      logic [DATA_W-1:0] typed_product;
   } step_type;

   localparam int NUM_STEPS = 23;
   localparam step_type DIRECTED [0:NUM_STEPS-1] = '{
      '{STEP_CSR,  CSR_ROWS_A,    3'd0, 3'd0, 32'd1,          1'b0, 32'd0},
      '{STEP_CSR,  CSR_INNER_DIM, 3'd0, 3'd0, 32'd1,          1'b0, 32'd0},
      '{STEP_CSR,  CSR_COLS_B,    3'd0, 3'd0, 32'd1,          1'b0, 32'd0},
      '{STEP_WORD, OP_LOAD_A,     3'd0, 3'd0, 32'h7FFF_FFFF,  1'b0, 32'd0},
      '{STEP_WORD, OP_LOAD_B,     3'd0, 3'd0, 32'h7FFF_FFFF,  1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd0, 3'd0, 32'd0,          1'b1, 32'd1},
      '{STEP_WORD, OP_LOAD_A,     3'd0, 3'd0, 32'h8000_0000,  1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd0, 3'd0, 32'd0,          1'b1, 32'h8000_0000},
      '{STEP_WORD, OP_LOAD_B,     3'd0, 3'd0, 32'hFFFF_FFFF,  1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd7, 3'd7, 32'hFFFF_FFFF,  1'b1, 32'h8000_0000},
      '{STEP_WORD, OP_UNUSED,     3'd0, 3'd0, 32'd5,          1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd0, 3'd0, 32'd0,          1'b1, 32'h8000_0000},
      '{STEP_WORD, OP_LOAD_A,     3'd7, 3'd7, 32'hFFFF_FFFF,  1'b0, 32'd0},
      '{STEP_WORD, OP_LOAD_B,     3'd7, 3'd7, 32'hFFFF_FFFF,  1'b0, 32'd0},
      '{STEP_CSR,  CSR_ROWS_A,    3'd0, 3'd0, 32'd0,          1'b0, 32'd0},
      '{STEP_CSR,  CSR_INNER_DIM, 3'd0, 3'd0, 32'd0,          1'b0, 32'd0},
      '{STEP_CSR,  CSR_COLS_B,    3'd0, 3'd0, 32'd0,          1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd0, 3'd0, 32'd0,          1'b1, 32'h8000_0000},
      '{STEP_WORD, OP_LOAD_A,     3'd0, 3'd0, 32'd0,          1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd0, 3'd0, 32'd0,          1'b1, 32'd0},
      '{STEP_WORD, OP_LOAD_A,     3'd0, 3'd0, 32'd3,          1'b0, 32'd0},
      '{STEP_WORD, OP_LOAD_B,     3'd0, 3'd0, 32'hFFFF_FFFB,  1'b0, 32'd0},
      '{STEP_WORD, OP_COMPUTE,    3'd5, 3'd2, 32'h1234_5678,  1'b0, 32'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ROWS_A;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   imm_req_if req_if ();
   imm_rsp_if rsp_if ();

   int_matrix_multiply dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4ns clock = ~clock;

   logic [DATA_W-1:0] a_mat [MAX_DIM][MAX_DIM];
   logic [DATA_W-1:0] b_mat [MAX_DIM][MAX_DIM];
   bit                a_set [MAX_DIM][MAX_DIM];
   bit                b_set [MAX_DIM][MAX_DIM];
   logic [DIM_W-1:0]  rows_cfg  = DIM_RESET;
   logic [DIM_W-1:0]  inner_cfg = DIM_RESET;
   logic [DIM_W-1:0]  cols_cfg  = DIM_RESET;

   product_elem_type pending_products [$];
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               max_gap = 4;
   int               max_stall = 4;
   bit               hold_armed = 1'b0;
   bit               hold_done = 1'b0;

   function automatic int eff_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void predict_word(opcode_type op, logic [IDX_W-1:0] r,
                                        logic [IDX_W-1:0] c, logic [DATA_W-1:0] v);
      int                n, m, p;
      logic [DATA_W-1:0] acc;
      product_elem_type  e;
      n = eff_dim(rows_cfg);
      m = eff_dim(inner_cfg);
      p = eff_dim(cols_cfg);
      case (op)
         OP_LOAD_A: begin
            a_mat[r][c] = v;
            a_set[r][c] = 1'b1;
         end
         OP_LOAD_B: begin
            b_mat[r][c] = v;
            b_set[r][c] = 1'b1;
         end
         OP_COMPUTE: begin
            for (int i = 0; i < n; i++) begin
               for (int k = 0; k < p; k++) begin
                  acc = '0;
                  for (int j = 0; j < m; j++) acc = acc + a_mat[i][j] * b_mat[j][k];
                  e.row_idx = IDX_W'(i);
                  e.col_idx = IDX_W'(k);
                  e.product = acc;
                  e.last    = (i == n - 1) && (k == p - 1);
                  pending_products.push_back(e);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return '1;
         4: return DATA_W'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 4'd15;
         2: return 4'd8;
         3: return DIM_W'($urandom_range(9, 15));
         default: return DIM_W'($urandom_range(1, 4));
      endcase
   endfunction

   // drop valid, let every product word arrive, then let queued loads settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROWS_A:    rows_cfg  = data;
         CSR_INNER_DIM: inner_cfg = data;
         CSR_COLS_B:    cols_cfg  = data;
         default: ;
      endcase
   endtask

   task automatic send_word(opcode_type op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                            logic [DATA_W-1:0] v, bit typed = 1'b0,
                            logic [DATA_W-1:0] typed_product = '0);
      int               gap;
      product_elem_type e;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.opcode <= op;
      req_if.row    <= r;
      req_if.col    <= c;
      req_if.value  <= v;
      do @(posedge clock); while (!req_if.ready);
      if (typed && op == OP_COMPUTE) begin
         e.row_idx = '0;
         e.col_idx = '0;
         e.product = typed_product;
         e.last    = 1'b1;
         pending_products.push_back(e);
      end else begin
         predict_word(op, r, c, v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : product_sink
      int               stall;
      product_elem_type want;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, max_stall);
         if (hold_armed && !hold_done) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (pending_products.size() == 0) begin
            $error("unexpected product word: out_row %0d out_col %0d product %0d",
                   rsp_if.out_row, rsp_if.out_col, rsp_if.product);
            mismatch_count++;
         end else begin
            want = pending_products.pop_front();
            if (rsp_if.out_row !== want.row_idx) begin
               $error("out_row: expected %0d actual %0d", want.row_idx, rsp_if.out_row);
               mismatch_count++;
            end
            if (rsp_if.out_col !== want.col_idx) begin
               $error("out_col: expected %0d actual %0d", want.col_idx, rsp_if.out_col);
               mismatch_count++;
            end
            if (rsp_if.product !== want.product) begin
               $error("product: expected %0d actual %0d", want.product, rsp_if.product);
               mismatch_count++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, rsp_if.last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : word_source
      step_type s;
      int       words_sent;
      int       n, m, p, rounds, loads;
      words_sent = 0;
      req_if.valid  <= 1'b0;
      req_if.opcode <= OP_LOAD_A;
      req_if.row    <= '0;
      req_if.col    <= '0;
      req_if.value  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_STEPS; i++) begin
         s = DIRECTED[i];
         if (s.kind == STEP_CSR) begin
            write_csr(csr_index_type'(s.code), s.value[CSR_DATA_W-1:0]);
         end else begin
            send_word(opcode_type'(s.code), s.row, s.col, s.value, s.typed, s.typed_product);
         end
      end

      while (words_sent < RANDOM_WORDS) begin
         write_csr(CSR_ROWS_A, pick_dim());
         write_csr(CSR_INNER_DIM, pick_dim());
         write_csr(CSR_COLS_B, pick_dim());
         n = eff_dim(rows_cfg);
         m = eff_dim(inner_cfg);
         p = eff_dim(cols_cfg);
         max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 4;
         max_stall = ($urandom_range(0, 3) == 0) ? 0 : 4;
         rounds = $urandom_range(1, 3);
         for (int rnd = 0; rnd < rounds; rnd++) begin
            loads = $urandom_range(1, 6) + ((hold_armed && !hold_done) ? 8 : 0);
            repeat (loads) begin
               if ($urandom_range(0, 1)) begin
                  send_word(OP_LOAD_A, IDX_W'($urandom_range(0, n - 1)),
                            IDX_W'($urandom_range(0, m - 1)), draw_value());
               end else begin
                  send_word(OP_LOAD_B, IDX_W'($urandom_range(0, m - 1)),
                            IDX_W'($urandom_range(0, p - 1)), draw_value());
               end
               words_sent++;
            end
            // fill whatever the product will read that was never written
            for (int i = 0; i < n; i++) begin
               for (int j = 0; j < m; j++) begin
                  if (!a_set[i][j]) begin
                     send_word(OP_LOAD_A, IDX_W'(i), IDX_W'(j), draw_value());
                     words_sent++;
                  end
               end
            end
            for (int j = 0; j < m; j++) begin
               for (int k = 0; k < p; k++) begin
                  if (!b_set[j][k]) begin
                     send_word(OP_LOAD_B, IDX_W'(j), IDX_W'(k), draw_value());
                     words_sent++;
                  end
               end
            end
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1)) begin
                  send_word(OP_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
               end else begin
                  send_word($urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B,
                            IDX_W'($urandom()), IDX_W'($urandom()), draw_value());
                  words_sent++;
               end
            end
            send_word(OP_COMPUTE, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
            words_sent++;
            if (rnd < rounds - 1 && n * p >= 4 && !hold_done) hold_armed = 1'b1;
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
